// ----- hw/rtl/rwf_pkg.sv -----
// Shared types and constants for the replay window filter.
// Holds the controller state encoding, the item class codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package rwf_pkg;

    localparam int WIN_BITS_DEF = 8192;
    localparam int WORD_BITS    = 64;
    localparam int SEQ_W        = 32;

    // What the distance to the highest sequence says about an incoming word.
    typedef enum logic [2:0] {
        CL_FIRST,
        CL_REJECT,
        CL_FWD_NEAR,
        CL_FWD_FAR,
        CL_BACK_NEAR
    } t_class;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_CLEAR,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_MARK_RD,
        ST_MARK_WR
    } t_state;

    typedef struct packed {
        logic load;
        logic plan;
        logic clear_step;
        logic take_mod;
        logic rd_sweep;
        logic sweep_wr;
        logic rd_target;
        logic mark_wr;
        logic reply_reject;
    } t_cmd;

    typedef struct packed {
        t_class cls;
        logic   clear_end;
        logic   mod_done;
        logic   sweep_last;
    } t_stat;

endpackage

// ----- hw/rtl/rwf_mod.sv -----
// Remainder unit: 32-bit value modulo the window size by reciprocal multiplication.
// Depends on rwf_pkg.
`timescale 1ns / 1ps

module rwf_mod import rwf_pkg::*; #(
    parameter int WINDOW_BITS = WIN_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [SEQ_W-1:0]                 i_value,
    output logic                             o_busy,
    output logic [$clog2(WINDOW_BITS)-1:0]   o_rem
);

    localparam int SLOT_W  = $clog2(WINDOW_BITS);
    localparam int WIDE_W  = SLOT_W + 1;
    localparam int SHIFT   = SEQ_W + SLOT_W;
    localparam int RECIP_W = SEQ_W + 1;
    localparam int PROD_W  = SEQ_W + RECIP_W;
    // The reciprocal is rounded down, so the quotient estimate is low by at most one and
    // the first remainder estimate lies below twice the window.
    localparam logic [63:0]        RECIP_FULL = (64'd1 << SHIFT) / 64'(WINDOW_BITS);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
    localparam logic [WIDE_W-1:0]  WIN_WIDE   = WIDE_W'(WINDOW_BITS);

    logic                r_busy;
    logic                r_stage;
    logic [SEQ_W-1:0]    r_val;
    logic [WIDE_W-1:0]   r_quo;
    logic [SLOT_W-1:0]   r_rem;
    logic [PROD_W-1:0]   prod;
    logic [2*WIDE_W-1:0] quo_win;
    logic [WIDE_W-1:0]   est;
    logic [SLOT_W-1:0]   n_rem;

    // A quotient estimate is registered first; then the remainder is formed by subtraction and corrected once.
    // Only the low bits of the quotient matter, since the remainder is small.
    always_comb begin
        prod    = {{RECIP_W{1'b0}}, r_val} * {{SEQ_W{1'b0}}, RECIP};
        quo_win = {{WIDE_W{1'b0}}, r_quo} * {{WIDE_W{1'b0}}, WIN_WIDE};
        est     = r_val[WIDE_W-1:0] - quo_win[WIDE_W-1:0];
        if (est >= WIN_WIDE) begin
            n_rem = SLOT_W'(est - WIN_WIDE);
        end else begin
            n_rem = SLOT_W'(est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_stage <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_stage <= 1'b1;
        end else if (r_stage) begin
            r_stage <= 1'b0;
        end else if (r_busy) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_stage) begin
            r_quo <= prod[SHIFT +: WIDE_W];
        end
        if (r_busy && !r_stage) begin
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/rwf_datapath.sv -----
// Datapath of the replay window filter: window state, bitmap memory and result register.
// Depends on rwf_pkg and rwf_mod.
`timescale 1ns / 1ps

module rwf_datapath import rwf_pkg::*; #(
    parameter int WINDOW_BITS = WIN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [SEQ_W-1:0] i_sequence_number,
    output logic             o_valid,
    output logic             o_accepted
);

    localparam int SLOT_W    = $clog2(WINDOW_BITS);
    localparam int WIDE_W    = SLOT_W + 1;
    localparam int MAP_WORDS = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PTR_W     = $clog2(MAP_WORDS + 1);
    localparam logic [WIDE_W-1:0] WIN_WIDE = WIDE_W'(WINDOW_BITS);
    localparam logic [SEQ_W-1:0]  WIN_SEQ  = SEQ_W'(WINDOW_BITS);
    localparam logic [PTR_W-1:0]  PTR_END  = PTR_W'(MAP_WORDS);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [SEQ_W-1:0]     r_seq;
    logic [SEQ_W-1:0]     r_high;
    logic                 r_started;
    t_class               r_class;
    logic [SLOT_W-1:0]    r_delta;
    logic [SLOT_W-1:0]    r_high_slot;
    logic [SLOT_W-1:0]    r_target;
    logic [SLOT_W-1:0]    r_pos;
    logic [SLOT_W-1:0]    r_rem;
    logic [PTR_W-1:0]     r_clr_ptr;
    logic [WORD_BITS-1:0] r_rd_word;
    logic                 r_valid;
    logic                 r_accepted;

    logic [SEQ_W-1:0]     fwd_diff;
    logic [SEQ_W-1:0]     back_diff;
    t_class               n_class;
    logic [SLOT_W-1:0]    n_delta;

    logic [WIDE_W-1:0]    fwd_sum;
    logic [SLOT_W-1:0]    slot_fwd;
    logic [WIDE_W-1:0]    pos_inc;
    logic [SLOT_W-1:0]    slot_next;
    logic [WIDE_W-1:0]    back_sub;
    logic [SLOT_W-1:0]    slot_back;

    logic [5:0]           ofs;
    logic [6:0]           room_word;
    logic [WIDE_W-1:0]    room_wrap;
    logic [WIDE_W-1:0]    run_wide;
    logic [6:0]           run;
    logic [6:0]           top_bit;
    logic [WORD_BITS-1:0] run_mask;
    logic [WORD_BITS-1:0] mark_mask;
    logic                 sweep_last;
    logic [WORD_BITS-1:0] sweep_word;
    logic [WIDE_W-1:0]    pos_sum;
    logic [SLOT_W-1:0]    n_pos;

    logic                 tgt_bit;
    logic [WORD_BITS-1:0] tgt_word;

    logic                 mod_busy;
    logic [SLOT_W-1:0]    mod_rem;
    logic                 mod_start;

    logic                 mem_we;
    logic [WORD_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_W-1:0]    mem_raddr;
    logic                 n_valid;
    logic                 n_accepted;

    // Classify an incoming word against the highest sequence seen so far.
    always_comb begin
        fwd_diff  = i_sequence_number - r_high;
        back_diff = r_high - i_sequence_number;
        n_delta   = fwd_diff[SLOT_W-1:0];
        if (!r_started) begin
            n_class = CL_FIRST;
        end else if (fwd_diff == '0) begin
            n_class = CL_REJECT;
        end else if (!fwd_diff[SEQ_W-1]) begin
            n_class = (fwd_diff >= WIN_SEQ) ? CL_FWD_FAR : CL_FWD_NEAR;
        end else begin
            n_delta = back_diff[SLOT_W-1:0];
            n_class = (back_diff >= WIN_SEQ) ? CL_REJECT : CL_BACK_NEAR;
        end
    end

    // Slot arithmetic relative to the slot of the highest sequence.
    always_comb begin
        fwd_sum  = {1'b0, r_high_slot} + {1'b0, r_delta};
        slot_fwd = (fwd_sum >= WIN_WIDE) ? SLOT_W'(fwd_sum - WIN_WIDE) : SLOT_W'(fwd_sum);
        pos_inc  = {1'b0, r_high_slot} + WIDE_W'(1);
        slot_next = (pos_inc == WIN_WIDE) ? '0 : SLOT_W'(pos_inc);
        back_sub = {1'b0, r_high_slot} - {1'b0, r_delta};
        if (r_high_slot < r_delta) begin
            back_sub = back_sub + WIN_WIDE;
        end
        slot_back = SLOT_W'(back_sub);
    end

    // One sweep step clears a run of bits inside one word, and the last step sets the run's
    // top bit; a run stops at the word end, at the window end and when the count is used up.
    always_comb begin
        ofs       = r_pos[5:0];
        room_word = 7'd64 - {1'b0, ofs};
        room_wrap = WIN_WIDE - {1'b0, r_pos};
        run_wide  = ({1'b0, r_rem} < room_wrap) ? {1'b0, r_rem} : room_wrap;
        if (run_wide > WIDE_W'(room_word)) begin
            run_wide = WIDE_W'(room_word);
        end
        run        = 7'(run_wide);
        run_mask   = ({WORD_BITS{1'b1}} >> (7'd64 - run)) << ofs;
        top_bit    = {1'b0, ofs} + run - 7'd1;
        mark_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << top_bit[5:0];
        sweep_last = ({1'b0, r_rem} == run_wide);
        sweep_word = (r_rd_word & ~run_mask) | (sweep_last ? mark_mask : '0);
        pos_sum    = {1'b0, r_pos} + run_wide;
        n_pos      = (pos_sum == WIN_WIDE) ? '0 : SLOT_W'(pos_sum);
    end

    always_comb begin
        tgt_bit  = r_rd_word[r_target[5:0]];
        tgt_word = r_rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << r_target[5:0]);
    end

    assign mod_start = i_cmd.plan && (r_class == CL_FIRST || r_class == CL_FWD_FAR);

    rwf_mod #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_value(r_seq),
        .o_busy (mod_busy),
        .o_rem  (mod_rem)
    );

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_ptr[WORD_W-1:0];
        mem_wdata = '0;
        if (i_cmd.clear_step && r_clr_ptr != PTR_END) begin
            mem_we = 1'b1;
        end else if (i_cmd.sweep_wr) begin
            mem_we    = 1'b1;
            mem_waddr = WORD_W'(r_pos >> 6);
            mem_wdata = sweep_word;
        end else if (i_cmd.mark_wr && !tgt_bit) begin
            mem_we    = 1'b1;
            mem_waddr = WORD_W'(r_target >> 6);
            mem_wdata = tgt_word;
        end
        mem_raddr = i_cmd.rd_sweep ? WORD_W'(r_pos >> 6) : WORD_W'(r_target >> 6);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_sweep || i_cmd.rd_target) begin
            r_rd_word <= mem[mem_raddr];
        end
    end

    always_comb begin
        n_valid    = i_cmd.reply_reject || (i_cmd.sweep_wr && sweep_last) || i_cmd.mark_wr;
        n_accepted = i_cmd.mark_wr ? !tgt_bit : !i_cmd.reply_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_valid   <= 1'b0;
            r_clr_ptr <= '0;
        end else begin
            r_valid <= n_valid;
            if (mod_start) begin
                r_started <= 1'b1;
                r_clr_ptr <= '0;
            end else if (i_cmd.clear_step && r_clr_ptr != PTR_END) begin
                r_clr_ptr <= r_clr_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        if (i_cmd.load) begin
            r_seq   <= i_sequence_number;
            r_class <= n_class;
            r_delta <= n_delta;
        end
        if (i_cmd.plan) begin
            unique case (r_class)
                CL_FIRST, CL_FWD_FAR: begin
                    r_high <= r_seq;
                end
                CL_FWD_NEAR: begin
                    r_high      <= r_seq;
                    r_high_slot <= slot_fwd;
                    r_target    <= slot_fwd;
                    r_pos       <= slot_next;
                    r_rem       <= r_delta;
                end
                CL_BACK_NEAR: begin
                    r_target <= slot_back;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.take_mod) begin
            r_high_slot <= mod_rem;
            r_target    <= mod_rem;
        end
        if (i_cmd.sweep_wr) begin
            r_pos <= n_pos;
            r_rem <= SLOT_W'({1'b0, r_rem} - run_wide);
        end
    end

    assign o_stat.cls        = r_class;
    assign o_stat.clear_end  = (r_clr_ptr == PTR_END);
    assign o_stat.mod_done   = !mod_busy;
    assign o_stat.sweep_last = sweep_last;
    assign o_valid           = r_valid;
    assign o_accepted        = r_accepted;

endmodule

// ----- hw/rtl/rwf_ctrl.sv -----
// Controller of the replay window filter: sequences plan, clear, sweep and mark steps.
// Depends on rwf_pkg.
`timescale 1ns / 1ps

module rwf_ctrl import rwf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                unique case (i_stat.cls)
                    CL_FIRST, CL_FWD_FAR: n_state = ST_CLEAR;
                    CL_FWD_NEAR:          n_state = ST_SWEEP_RD;
                    CL_BACK_NEAR:         n_state = ST_MARK_RD;
                    default:              n_state = ST_IDLE;
                endcase
            end
            ST_CLEAR: begin
                if (i_stat.clear_end && i_stat.mod_done) begin
                    n_state = ST_MARK_RD;
                end
            end
            ST_SWEEP_RD: n_state = ST_SWEEP_WR;
            ST_SWEEP_WR: begin
                n_state = i_stat.sweep_last ? ST_IDLE : ST_SWEEP_RD;
            end
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_PLAN: begin
                o_cmd.plan         = 1'b1;
                o_cmd.reply_reject = (i_stat.cls == CL_REJECT);
            end
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                o_cmd.take_mod   = i_stat.clear_end && i_stat.mod_done;
            end
            ST_SWEEP_RD: o_cmd.rd_sweep  = 1'b1;
            ST_SWEEP_WR: o_cmd.sweep_wr  = 1'b1;
            ST_MARK_RD:  o_cmd.rd_target = 1'b1;
            ST_MARK_WR:  o_cmd.mark_wr   = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/replay_window_filter.sv -----
// Top level of the replay window filter: sliding-window duplicate detector for sequence numbers.
// Depends on rwf_pkg, rwf_ctrl and rwf_datapath (which holds rwf_mod).
`timescale 1ns / 1ps

// Channel   Direction  Signals                         Handshake
// -------   ---------  ------------------------------  -------------------------------------
// item      in         i_sequence_number               taken at a clock edge with start && !busy
// result    out        o_accepted                      shown for one cycle while o_valid is high
//
// An item equal to the highest number, or a whole window or more behind it, is rejected while
// planning, and the controller then returns to idle.
// An item behind the highest one but inside the window takes one planning step and a
// read-modify-write of the bitmap memory, which has one read and one write port; a forward
// step inside the window plans once and then does one such read-modify-write per bitmap word.
// The first item and any jump of a whole window or more clear the map word by word; the
// remainder unit that finds the new bit position runs while the clear runs, and the new bit
// is marked once both are done.
// Reset is synchronous; no clearing pass runs after it, since the first item clears the map.
// The receiver cannot stall: each result word is presented for exactly one cycle.

module replay_window_filter import rwf_pkg::*; #(
    parameter int WINDOW_BITS = WIN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [SEQ_W-1:0] i_sequence_number,
    output logic             o_valid,
    output logic             o_accepted
);

    // The controller only issues commands; all window state lives in the datapath.
    t_cmd  cmd;
    t_stat stat;

    rwf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    rwf_datapath #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sequence_number(i_sequence_number),
        .o_valid          (o_valid),
        .o_accepted       (o_accepted)
    );

    // A result word is only produced by work that was in flight in the cycle before.
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // Every reply returns the controller to idle, so the block is free while a result shows.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    // One item gives one result: strobes can never come in consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // An accepted item always occupies the block in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

endmodule
